// ----- rtl/txj_pkg.sv -----
// Shared constants, codes and types of the transaction journal table.
package txj_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int LOG_DEPTH  = 8;

   localparam int CMD_W   = 3;
   localparam int ID_W    = 64;
   localparam int VALUE_W = 64;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 5;

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int FILL_W  = $clog2(LOG_DEPTH + 1);
   localparam int LOG_ENTRIES = SLOT_COUNT * LOG_DEPTH;
   localparam int LOG_AW  = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

   localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REPLAY = 3'd4;
   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd5;

   localparam logic [1:0] SLOT_FREE      = 2'd0;
   localparam logic [1:0] SLOT_ACTIVE    = 2'd1;
   localparam logic [1:0] SLOT_COMMITTED = 2'd2;
   localparam logic [1:0] SLOT_ABORTED   = 2'd3;

   localparam logic [STAT_W-1:0] RES_OK     = 2'd0;
   localparam logic [STAT_W-1:0] RES_REJECT = 2'd1;
   localparam logic [STAT_W-1:0] RES_FULL   = 2'd2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic [ID_W-1:0]   ident;
      logic [1:0]        status;
      logic [FILL_W-1:0] fill;
   } slot_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);

endpackage

// ----- rtl/txj_if.sv -----
// Valid/ready channel interfaces for command and response beats.
interface txj_req_if;
   logic                            valid;
   logic                            ready;
   logic [txj_pkg::CMD_W-1:0]       cmd;
   logic [txj_pkg::ID_W-1:0]        tx_id;
   logic [txj_pkg::VALUE_W-1:0]     value;

   modport source (output valid, output cmd, output tx_id, output value, input ready);
   modport sink   (input valid, input cmd, input tx_id, input value, output ready);
endinterface

interface txj_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [txj_pkg::STAT_W-1:0]      status;
   logic [txj_pkg::ID_W-1:0]        issued_tx;
   logic [txj_pkg::TOTAL_W-1:0]     commit_total;

   modport source (output valid, output status, output issued_tx, output commit_total,
                   input ready);
   modport sink   (input valid, input status, input issued_tx, input commit_total,
                   output ready);
endinterface

// ----- rtl/transaction_journal_table.sv -----
// Transaction journal table: slot table and value log with a scanning sequencer.
//
// Usage:
//   req_chan carries one command beat (cmd, tx_id, value); rsp_chan returns
//   exactly one response beat (status, issued_tx, commit_total) per command.
//   Both channels transfer a beat when valid and ready are high at a clock edge.
//   Commands are handled one at a time; req_chan.ready is high only while the
//   sequencer is idle, and a finished response may still wait in the output
//   register while the next command is accepted.
//   Init, unknown commands and begin/replay before init go straight from the
//   idle state to the done state. Begin, append, commit and abort scan the slot
//   table from slot 0 and stop at the first hit; replay visits every slot. The
//   scan is paced by the slot table memory, which returns one slot per cycle.
//   Reset: synchronous, active high; the table reads as all free, counters are
//   zero and the ready flag is clear until an init command is given.
//   Stall: if rsp_chan.ready is low the response holds in the output register;
//   a following command that finishes meanwhile waits in its done state.
module transaction_journal_table (
   input  logic      clock,
   input  logic      reset,
   txj_req_if.sink   req_chan,
   txj_rsp_if.source rsp_chan
);
   import txj_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic                  ready_flag_ff, ready_flag_in;
   logic [ID_W-1:0]       counter_ff, counter_in;
   logic [TOTAL_W-1:0]    commit_ff, commit_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [STAT_W-1:0]     res_status_ff, res_status_in;
   logic [ID_W-1:0]       res_issued_ff, res_issued_in;
   logic [TOTAL_W-1:0]    res_total_ff, res_total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_issued_ff, rsp_issued_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;

   slot_entry_type        slot_rd_raw, slot_rd, slot_wr;
   logic                  slot_we;
   logic [SLOT_W-1:0]     slot_rd_addr;
   logic                  log_we;
   logic [LOG_AW-1:0]     log_addr;
   logic [VALUE_W-1:0]    log_rd_data;
   logic                  last_slot;
   logic [ID_W-1:0]       next_id;
   logic                  accept;
   logic                  out_free;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_slot = (idx_ff == SLOT_W'(SLOT_COUNT - 1));
   assign next_id   = counter_ff + 1'b1;
   assign log_addr  = LOG_AW'(LOG_AW'(idx_ff) * LOG_AW'(LOG_DEPTH)) + LOG_AW'(slot_rd.fill);

   always_comb begin
      slot_rd = slot_rd_raw;
      if (!valid_ff[idx_ff]) begin
         slot_rd = '0;
      end
   end

   always_comb begin
      if (state_ff == ST_SCAN && !last_slot) begin
         slot_rd_addr = idx_ff + 1'b1;
      end else begin
         slot_rd_addr = '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      val_in        = val_ff;
      ready_flag_in = ready_flag_ff;
      counter_in    = counter_ff;
      commit_in     = commit_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_issued_in = res_issued_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_issued_in = rsp_issued_ff;
      rsp_total_in  = rsp_total_ff;
      slot_we       = 1'b0;
      slot_wr       = slot_rd;
      log_we        = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_chan.cmd;
               id_in         = req_chan.tx_id;
               val_in        = req_chan.value;
               idx_in        = '0;
               res_status_in = RES_REJECT;
               res_issued_in = '0;
               res_total_in  = '0;
               case (req_chan.cmd) inside
                  CMD_BEGIN, CMD_REPLAY: begin
                     state_in = ready_flag_ff ? ST_SCAN : ST_DONE;
                  end
                  CMD_APPEND, CMD_COMMIT, CMD_ABORT: begin
                     state_in = ST_SCAN;
                  end
                  CMD_INIT: begin
                     ready_flag_in = 1'b1;
                     counter_in    = '0;
                     commit_in     = '0;
                     valid_in      = '0;
                     res_status_in = RES_OK;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            case (cmd_ff) inside
               CMD_BEGIN: begin
                  if (slot_rd.status == SLOT_FREE) begin
                     slot_we        = 1'b1;
                     slot_wr.ident  = next_id;
                     slot_wr.status = SLOT_ACTIVE;
                     slot_wr.fill   = '0;
                     counter_in     = next_id;
                     res_status_in  = RES_OK;
                     res_issued_in  = next_id;
                     state_in       = ST_DONE;
                  end else if (last_slot) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               CMD_APPEND, CMD_COMMIT, CMD_ABORT: begin
                  if (slot_rd.status != SLOT_FREE && slot_rd.ident == id_ff) begin
                     state_in = ST_DONE;
                     if (slot_rd.status == SLOT_ACTIVE) begin
                        if (cmd_ff == CMD_APPEND) begin
                           if (slot_rd.fill >= FILL_W'(LOG_DEPTH)) begin
                              res_status_in = RES_FULL;
                           end else begin
                              log_we        = 1'b1;
                              slot_we       = 1'b1;
                              slot_wr.fill  = slot_rd.fill + 1'b1;
                              res_status_in = RES_OK;
                           end
                        end else if (cmd_ff == CMD_COMMIT) begin
                           slot_we        = 1'b1;
                           slot_wr.status = SLOT_COMMITTED;
                           if (commit_ff != TOTAL_MAX) begin
                              commit_in = commit_ff + 1'b1;
                           end
                           res_status_in = RES_OK;
                        end else begin
                           slot_we        = 1'b1;
                           slot_wr.status = SLOT_ABORTED;
                           res_status_in  = RES_OK;
                        end
                     end
                  end else if (last_slot) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               CMD_REPLAY: begin
                  if (slot_rd.status == SLOT_COMMITTED || slot_rd.status == SLOT_ABORTED) begin
                     slot_we        = 1'b1;
                     slot_wr.status = SLOT_FREE;
                     slot_wr.ident  = '0;
                  end
                  if (last_slot) begin
                     res_status_in = RES_OK;
                     res_total_in  = commit_ff;
                     commit_in     = '0;
                     state_in      = ST_DONE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_issued_in = res_issued_ff;
               rsp_total_in  = res_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (slot_we) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_flag_ff <= 1'b0;
         counter_ff    <= '0;
         commit_ff     <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ready_flag_ff <= ready_flag_in;
         counter_ff    <= counter_in;
         commit_ff     <= commit_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_issued_ff <= res_issued_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_issued_ff <= rsp_issued_in;
      rsp_total_ff  <= rsp_total_in;
   end

   txj_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (idx_ff),
      .wr_data (slot_wr),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_raw)
   );

   txj_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (LOG_ENTRIES)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (log_we),
      .wr_addr (log_addr),
      .wr_data (val_ff),
      .rd_addr (log_addr),
      .rd_data (log_rd_data)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.issued_tx    = rsp_issued_ff;
   assign rsp_chan.commit_total = rsp_total_ff;

endmodule

// ----- rtl/txj_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module txj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/txj_chk.sv -----
// Port-level checker for the transaction journal table and its bind.
module txj_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [txj_pkg::STAT_W-1:0]   rsp_status,
   input logic [txj_pkg::ID_W-1:0]     rsp_issued_tx,
   input logic [txj_pkg::TOTAL_W-1:0]  rsp_commit_total
);
   import txj_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_issued_tx) && $stable(rsp_commit_total))
      else $error("response beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_issued_tx != '0 || rsp_commit_total != '0) |->
         rsp_status == RES_OK && (rsp_issued_tx == '0 || rsp_commit_total == '0))
      else $error("issued id or commit total on a failed or mixed response");

endmodule

bind transaction_journal_table txj_chk u_txj_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_issued_tx    (rsp_chan.issued_tx),
   .rsp_commit_total (rsp_chan.commit_total)
);

// ----- tb/tb_transaction_journal_table.sv -----
// Self-checking testbench for the transaction journal table: directed table, then random traffic.
module tb_transaction_journal_table;
   import txj_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int RESET_CYCLES   = 6;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int ITEMS_PER_PHASE = 256;
   localparam int PHASES         = 4;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ID_W-1:0]    issued_tx;
      logic [TOTAL_W-1:0] commit_total;
   } journal_rsp_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [ID_W-1:0]    tx_id;
      logic [VALUE_W-1:0] value;
      int                 reps;
      bit                 typed;
      journal_rsp_type    rsp;
   } plan_row_type;

   logic clock;
   logic reset;

   txj_req_if req_bus ();
   txj_rsp_if rsp_bus ();

   transaction_journal_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   int send_idle_pct;
   int rsp_stall_pct;
   int errors;
   journal_rsp_type pending_rsp_q[$];
   plan_row_type    plan[$];

   logic               jt_ready;
   logic [ID_W-1:0]    jt_counter;
   logic [TOTAL_W-1:0] jt_commits;
   logic [ID_W-1:0]    jt_ident [SLOT_COUNT];
   logic [1:0]         jt_state [SLOT_COUNT];
   int                 jt_fill  [SLOT_COUNT];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic journal_rsp_type make_rsp(logic [STAT_W-1:0] status,
                                                logic [ID_W-1:0] issued,
                                                logic [TOTAL_W-1:0] total);
      journal_rsp_type r;
      r.status       = status;
      r.issued_tx    = issued;
      r.commit_total = total;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         jt_ident[i] = '0;
         jt_state[i] = SLOT_FREE;
         jt_fill[i]  = 0;
      end
   endfunction

   function automatic int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (jt_state[i] != SLOT_FREE && jt_ident[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic journal_rsp_type journal_step(logic [CMD_W-1:0] cmd,
                                                    logic [ID_W-1:0] id);
      journal_rsp_type r;
      int s;
      r = make_rsp(RES_REJECT, '0, '0);
      case (cmd)
         CMD_BEGIN: begin
            if (jt_ready) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (jt_state[i] == SLOT_FREE) begin
                     jt_counter  = jt_counter + 1'b1;
                     jt_ident[i] = jt_counter;
                     jt_state[i] = SLOT_ACTIVE;
                     jt_fill[i]  = 0;
                     r = make_rsp(RES_OK, jt_counter, '0);
                     break;
                  end
               end
            end
         end
         CMD_APPEND: begin
            s = find_slot(id);
            if (s >= 0 && jt_state[s] == SLOT_ACTIVE) begin
               if (jt_fill[s] >= LOG_DEPTH) begin
                  r.status = RES_FULL;
               end else begin
                  jt_fill[s]++;
                  r.status = RES_OK;
               end
            end
         end
         CMD_COMMIT, CMD_ABORT: begin
            s = find_slot(id);
            if (s >= 0 && jt_state[s] == SLOT_ACTIVE) begin
               if (cmd == CMD_COMMIT) begin
                  jt_state[s] = SLOT_COMMITTED;
                  if (jt_commits != TOTAL_MAX) jt_commits = jt_commits + 1'b1;
               end else begin
                  jt_state[s] = SLOT_ABORTED;
               end
               r.status = RES_OK;
            end
         end
         CMD_REPLAY: begin
            if (jt_ready) begin
               r = make_rsp(RES_OK, '0, jt_commits);
               jt_commits = '0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (jt_state[i] == SLOT_COMMITTED || jt_state[i] == SLOT_ABORTED) begin
                     jt_state[i] = SLOT_FREE;
                     jt_ident[i] = '0;
                  end
               end
            end
         end
         CMD_INIT: begin
            jt_ready   = 1'b1;
            jt_counter = '0;
            jt_commits = '0;
            clear_table();
            r.status = RES_OK;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [ID_W-1:0] pick_target(bit prefer_active);
      int live[$];
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (jt_state[i] != SLOT_FREE) live.push_back(i);
      end
      if (live.size() == 0) return rand64();
      if (prefer_active && $urandom_range(99) < 60) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (jt_state[i] == SLOT_ACTIVE) return jt_ident[i];
         end
      end
      return jt_ident[live[$urandom_range(live.size() - 1)]];
   endfunction

   function automatic void add_row(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                   logic [VALUE_W-1:0] value, int reps, bit typed,
                                   journal_rsp_type rsp);
      plan_row_type row;
      row.cmd   = cmd;
      row.tx_id = id;
      row.value = value;
      row.reps  = reps;
      row.typed = typed;
      row.rsp   = rsp;
      plan.push_back(row);
   endfunction

   // Enter and leave at a falling edge; valid stays high after the beat.
   task automatic drive_beat(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                             logic [VALUE_W-1:0] value);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.tx_id <= id;
      req_bus.value <= value;
      do begin
         @(posedge clock);
         taken = req_bus.valid && req_bus.ready;
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic run_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [VALUE_W-1:0] value, bit typed, journal_rsp_type typed_rsp);
      journal_rsp_type predicted;
      predicted = journal_step(cmd, id);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      drive_beat(cmd, id, value);
   endtask

   task automatic run_random_item();
      int r;
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      r  = $urandom_range(99);
      id = rand64();
      if (r < 25) cmd = CMD_BEGIN;
      else if (r < 60) begin
         cmd = CMD_APPEND;
         id  = pick_target(1'b1);
      end else if (r < 70) begin
         cmd = CMD_COMMIT;
         id  = pick_target(1'b0);
      end else if (r < 80) begin
         cmd = CMD_ABORT;
         id  = pick_target(1'b0);
      end else if (r < 88) cmd = CMD_REPLAY;
      else if (r < 90) cmd = CMD_INIT;
      else if (r < 97) cmd = CMD_W'($urandom_range(CMD_APPEND, CMD_ABORT));
      else cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      run_item(cmd, id, rand64(), 1'b0, make_rsp(RES_OK, '0, '0));
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      journal_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response beat with nothing pending");
            errors++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.issued_tx !== want.issued_tx) begin
               $error("issued_tx: expected %0h, got %0h", want.issued_tx, rsp_bus.issued_tx);
               errors++;
            end
            if (rsp_bus.commit_total !== want.commit_total) begin
               $error("commit_total: expected %0d, got %0d",
                      want.commit_total, rsp_bus.commit_total);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int idle_pct [PHASES];
      int stall_pct [PHASES];
      journal_rsp_type none;
      idle_pct  = '{0, 81, 0, 22};
      stall_pct = '{0, 0, 81, 22};
      none = make_rsp(RES_OK, '0, '0);
      errors        = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= '0;
      req_bus.tx_id <= '0;
      req_bus.value <= '0;
      jt_ready   = 1'b0;
      jt_counter = '0;
      jt_commits = '0;
      clear_table();

      add_row(CMD_BEGIN,    '0, '0, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_REPLAY,   '0, '0, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_APPEND,   '0, '1, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_SPARE_HI, '1, '1, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_INIT,     '0, '0, 1, 1, make_rsp(RES_OK, '0, '0));
      add_row(CMD_BEGIN,    '1, '0, 1, 1, make_rsp(RES_OK, 64'd1, '0));
      add_row(CMD_APPEND, 64'd1, '0, 1, 1, make_rsp(RES_OK, '0, '0));
      add_row(CMD_APPEND, 64'd1, '1, 1, 1, make_rsp(RES_OK, '0, '0));
      add_row(CMD_COMMIT, 64'd1, '0, 1, 1, make_rsp(RES_OK, '0, '0));
      add_row(CMD_APPEND, 64'd1, '0, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_BEGIN,    '0, '0, 1, 1, make_rsp(RES_OK, 64'd2, '0));
      add_row(CMD_ABORT,  64'd2, '0, 1, 0, none);
      add_row(CMD_REPLAY,   '0, '0, 1, 1, make_rsp(RES_OK, '0, 5'd1));
      add_row(CMD_SPARE_LO, '0, '0, 1, 1, make_rsp(RES_REJECT, '0, '0));
      add_row(CMD_INIT,     '1, '1, 1, 1, make_rsp(RES_OK, '0, '0));
      add_row(CMD_BEGIN,    '0, '0, 1, 1, make_rsp(RES_OK, 64'd1, '0));
      add_row(CMD_APPEND, 64'd1, 64'hA5A5_5A5A_0F0F_F0F0, LOG_DEPTH, 0, none);
      add_row(CMD_APPEND, 64'd1, '1, 1, 1, make_rsp(RES_FULL, '0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         repeat (plan[i].reps)
            run_item(plan[i].cmd, plan[i].tx_id, plan[i].value, plan[i].typed, plan[i].rsp);
      end

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = idle_pct[p];
         rsp_stall_pct = stall_pct[p];
         repeat (ITEMS_PER_PHASE) run_random_item();
      end

      req_bus.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
